// ----- sv/tdf_pkg.sv -----
// Shared types and constants for the timer prescaler/period factoring block.
// Used by tdf_divider, tdf_isqrt and timer_divider_factoring; no dependencies.
package tdf_pkg;

  // Width of the operands of the shared divider and of the rate/clock fields.
  localparam int unsigned DATA_W   = 32;
  // Integer root of a 32-bit value fits 16 bits; clock in MHz fits 13 bits.
  localparam int unsigned ROOT_W   = 16;
  localparam int unsigned MHZ_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // Timer tick used by the fallback path.
  localparam logic [DATA_W-1:0] TICK_HZ  = 32'd1000000;
  // Highest bit pair of the square root walk.
  localparam logic [DATA_W-1:0] SQRT_TOP = 32'h4000_0000;

  // Clock in MHz by reciprocal multiplication, exact for any 32-bit clock:
  // 1000000 = 64 * 15625, so ((clock >> 6) * MHZ_RECIP) >> MHZ_SHIFT.
  localparam int unsigned TICK_LOG2 = 6;
  localparam int unsigned MHZ_SHIFT = 40;
  localparam logic [26:0] MHZ_RECIP = 27'd70368745;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

  // Handshake status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- sv/tdf_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tdf_pkg for widths and the unit status struct.
module tdf_divider import tdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic [DATA_W-1:0] quotient_o,
  output logic [DATA_W-1:0] remainder_o,
  output unit_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // One shift-compare-subtract step
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DATA_W-2:0], ge};
      rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/tdf_isqrt.sv -----
// Bit-pair integer square root of a 32-bit value, one root bit per cycle.
// Depends on tdf_pkg for widths, the start constant and the status struct.
module tdf_isqrt import tdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] value_i,
  output logic [ROOT_W-1:0] root_o,
  output unit_stat_t        stat_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] root_q, root_d;
  logic [DATA_W-1:0] bit_q, bit_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DATA_W:0]   trial;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  always_comb begin
    val_d  = val_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      root_d = '0;
      bit_d  = SQRT_TOP;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, val_q} >= trial) begin
        val_d  = val_q - trial[DATA_W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      // last bit pair reached
      if (bit_q == DATA_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    root_q <= root_d;
  end

  assign root_o = root_q[ROOT_W-1:0];
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/timer_divider_factoring.sv -----
// Top level: sequencer that factors clock_hz / rate_hz into prescaler and period.
// Depends on tdf_pkg, tdf_divider (shared divider) and tdf_isqrt.
//
// Use: write the timer clock in hertz through cfg_we_i/cfg_wdata_i (reset value
// 72 MHz) while the block is idle. Raise start with rate_hz_i; the request is
// transferred on a rising edge where start is high and busy is low. For a
// non-zero rate busy then stays high until the result is ready. The result
// appears for exactly one cycle with done_o high; the receiver must take it
// then, it cannot stall. A zero rate answers in the cycle right after the
// transfer. Otherwise the shared divider forms the ratio, and a rate above the
// clock (ratio zero) ends there with a bad-rate status; the clock in MHz comes
// from a constant multiply at the transfer. The root unit gives the first
// candidate, and the downward divisor search skips a candidate rejected on
// counter range without a division and uses the shared divider for each
// candidate tried and for the 1 MHz fallback. A last division forms the
// achieved rate unless the product of the counts is zero or above 32 bits.
// Items are handled one at a time. Reset returns the block to idle, restores
// the clock register and drops any request in progress; no result is produced
// for it.
module timer_divider_factoring import tdf_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [DATA_W-1:0]       cfg_wdata_i,
  input  logic [DATA_W-1:0]       rate_hz_i,
  output logic                    done_o,
  output logic [COUNTER_BITS-1:0] prescale_minus_one_o,
  output logic [COUNTER_BITS-1:0] period_minus_one_o,
  output logic [DATA_W-1:0]       achieved_hz_o,
  output logic [STATUS_W-1:0]     status_o
);

  localparam int unsigned CB   = COUNTER_BITS;
  localparam int unsigned PW   = 2 * COUNTER_BITS;
  localparam int unsigned PMW  = ROOT_W + MHZ_W;
  localparam int unsigned MMW  = DATA_W - TICK_LOG2 + $bits(MHZ_RECIP);
  localparam logic [DATA_W-1:0] CMASK = DATA_W'((64'd1 << COUNTER_BITS) - 64'd1);

  // Sequencer states
  localparam int unsigned SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_RATIO = 4'd1;
  localparam logic [SW-1:0] S_ROOT  = 4'd3;
  localparam logic [SW-1:0] S_CHECK = 4'd4;
  localparam logic [SW-1:0] S_TRY   = 4'd5;
  localparam logic [SW-1:0] S_FALL  = 4'd6;
  localparam logic [SW-1:0] S_PROD  = 4'd7;
  localparam logic [SW-1:0] S_ACH   = 4'd8;
  localparam logic [SW-1:0] S_ACHW  = 4'd9;

  logic [SW-1:0]       state_q, state_d;
  logic [DATA_W-1:0]   clock_q;
  logic [DATA_W-1:0]   rate_q;
  logic [DATA_W-1:0]   ratio_q;
  logic [MHZ_W-1:0]    mhz_q;
  logic [ROOT_W-1:0]   pm_q;
  logic [ROOT_W-1:0]   p1_q;
  logic [DATA_W-1:0]   p2_q;
  logic [CB-1:0]       p1t_q, p2t_q;
  logic [PW-1:0]       prod_q;
  logic                trunc_q;

  logic                done_q;
  logic [CB-1:0]       pre_q, per_q;
  logic [DATA_W-1:0]   ach_q;
  logic [STATUS_W-1:0] stat_q;

  // Shared divider and root unit hookup
  logic                div_start;
  logic [DATA_W-1:0]   div_a, div_b;
  logic [DATA_W-1:0]   div_quo, div_rem;
  unit_stat_t          div_stat;
  logic                sqrt_start;
  logic [ROOT_W-1:0]   sqrt_root;
  unit_stat_t          sqrt_stat;

  // Finishing request towards the result registers
  logic                fin;
  logic                fin_bad;
  logic [DATA_W-1:0]   fin_ach;
  logic [STATUS_W-1:0] fin_stat;

  logic                accept;
  logic [MMW-1:0]      mhz_mul;
  logic [PMW-1:0]      pm_prod;
  logic                pm_fits;
  logic [DATA_W-1:0]   p1_ext;
  logic                trunc_now;
  logic                prod_hi;

  tdf_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  // Root starts on the ratio straight from the divider
  tdf_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (div_quo),
    .root_o  (sqrt_root),
    .stat_o  (sqrt_stat)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Clock in MHz: constant reciprocal multiply
  assign mhz_mul = MMW'(clock_q[DATA_W-1:TICK_LOG2]) * MMW'(MHZ_RECIP);

  // Candidate range check: pm * clock-in-MHz must fit the counter
  assign pm_prod = PMW'(pm_q) * PMW'(mhz_q);
  assign pm_fits = DATA_W'(pm_prod) <= CMASK;

  // Count truncation
  assign p1_ext    = DATA_W'(p1_q);
  assign trunc_now = ((p1_ext | p2_q) & ~CMASK) != '0;
  assign prod_hi   = (64'(prod_q) >> DATA_W) != 64'd0;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    div_a      = clock_q;
    div_b      = rate_hz_i;
    sqrt_start = 1'b0;
    fin        = 1'b0;
    fin_bad    = 1'b0;
    fin_ach    = '0;
    fin_stat   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (rate_hz_i == '0) begin
            fin     = 1'b1;
            fin_bad = 1'b1;
          end else begin
            div_start = 1'b1;
            state_d   = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        if (div_stat.done) begin
          if (div_quo == '0) begin
            fin     = 1'b1;
            fin_bad = 1'b1;
            state_d = S_IDLE;
          end else begin
            sqrt_start = 1'b1;
            state_d    = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (sqrt_stat.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pm_q <= ROOT_W'(1)) begin
          div_start = 1'b1;
          div_a     = TICK_HZ;
          div_b     = rate_q;
          state_d   = S_FALL;
        end else if (pm_fits) begin
          div_start = 1'b1;
          div_a     = ratio_q;
          div_b     = DATA_W'(pm_q);
          state_d   = S_TRY;
        end
      end
      S_TRY: begin
        if (div_stat.done) begin
          state_d = (div_rem == '0) ? S_PROD : S_CHECK;
        end
      end
      S_FALL: begin
        if (div_stat.done) begin
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        state_d = S_ACH;
      end
      S_ACH: begin
        if (prod_q == '0) begin
          fin      = 1'b1;
          fin_stat = trunc_q ? ST_TRUNC : ST_ZERO_DIV;
          state_d  = S_IDLE;
        end else if (prod_hi) begin
          // product above any 32-bit clock: achieved rate is zero
          fin      = 1'b1;
          fin_stat = trunc_q ? ST_TRUNC : ST_OK;
          state_d  = S_IDLE;
        end else begin
          div_start = 1'b1;
          div_b     = DATA_W'(prod_q);
          state_d   = S_ACHW;
        end
      end
      S_ACHW: begin
        if (div_stat.done) begin
          fin      = 1'b1;
          fin_ach  = div_quo;
          fin_stat = trunc_q ? ST_TRUNC : ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      clock_q <= 32'd72000000;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (cfg_we_i) begin
        clock_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate_q <= rate_hz_i;
      mhz_q  <= MHZ_W'(mhz_mul >> MHZ_SHIFT);
    end
    if (state_q == S_RATIO && div_stat.done) begin
      ratio_q <= div_quo;
    end
    if (state_q == S_ROOT && sqrt_stat.done) begin
      pm_q <= sqrt_root;
    end
    // step to the next lower candidate
    if ((state_q == S_CHECK && pm_q > ROOT_W'(1) && !pm_fits) ||
        (state_q == S_TRY && div_stat.done && div_rem != '0)) begin
      pm_q <= pm_q - ROOT_W'(1);
    end
    if (state_q == S_TRY && div_stat.done && div_rem == '0) begin
      p1_q <= pm_q;
      p2_q <= div_quo;
    end
    if (state_q == S_FALL && div_stat.done) begin
      p1_q <= ROOT_W'(mhz_q);
      p2_q <= div_quo;
    end
    if (state_q == S_PROD) begin
      p1t_q   <= p1_ext[CB-1:0];
      p2t_q   <= p2_q[CB-1:0];
      trunc_q <= trunc_now;
      prod_q  <= PW'(p1_ext[CB-1:0]) * PW'(p2_q[CB-1:0]);
    end
  end

  // Result registers, loaded once per item
  always_ff @(posedge clk_i) begin
    if (fin) begin
      if (fin_bad) begin
        pre_q  <= '0;
        per_q  <= '0;
        ach_q  <= '0;
        stat_q <= ST_BAD_RATE;
      end else begin
        pre_q  <= p1t_q - CB'(1);
        per_q  <= p2t_q - CB'(1);
        ach_q  <= fin_ach;
        stat_q <= fin_stat;
      end
    end
  end

  assign done_o               = done_q;
  assign prescale_minus_one_o = pre_q;
  assign period_minus_one_o   = per_q;
  assign achieved_hz_o        = ach_q;
  assign status_o             = stat_q;

  // Checks
  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && rate_hz_i != '0) |=> busy)
    else $error("non-zero request did not make the block busy");

  a_units_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!div_stat.busy && !sqrt_stat.busy))
    else $error("arithmetic unit running while the sequencer is idle");

  a_zero_achieved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_BAD_RATE || status_o == ST_ZERO_DIV))
      |-> achieved_hz_o == '0)
    else $error("non-zero achieved rate reported with an error status");

  a_bad_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_BAD_RATE)
      |-> (prescale_minus_one_o == '0 && period_minus_one_o == '0))
    else $error("counts not cleared on a rejected request");

endmodule

// ----- bench/timer_divider_factoring_test.sv -----
// Self-checking bench for timer_divider_factoring: prescaler/period split of clock/rate.
// Needs tdf_pkg and the block's RTL; drives requests and clock writes, checks every result.
// Directed corner requests at several clock settings, then random requests per setting.
module timer_divider_factoring_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tdf_pkg::*;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned PHASE_RANDOM = 14;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [COUNT_W-1:0]  prescale;
    logic [COUNT_W-1:0]  period;
    logic [DATA_W-1:0]   achieved;
    logic [STATUS_W-1:0] status;
  } timer_split_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we = 1'b0;
  logic [DATA_W-1:0]   cfg_wdata = '0;
  logic [DATA_W-1:0]   rate_hz = '0;
  logic                done;
  logic [COUNT_W-1:0]  prescale_minus_one;
  logic [COUNT_W-1:0]  period_minus_one;
  logic [DATA_W-1:0]   achieved_hz;
  logic [STATUS_W-1:0] status;

  // Bench copy of the clock register, reset value as in the block
  logic [DATA_W-1:0] clock_model = 32'd72000000;
  logic [DATA_W-1:0] pending_rates[$];
  timer_split_t      expected_splits[$];
  bit                rate_taken = 1'b0;
  int                gap_left = 0;
  int                burst_left = 0;
  int                mismatches = 0;
  int                requests_sent = 0;
  int                clock_settings = 1;
  int                status_seen[4] = '{0, 0, 0, 0};

  timer_divider_factoring #(.COUNTER_BITS(COUNT_W)) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .rate_hz_i           (rate_hz),
    .done_o              (done),
    .prescale_minus_one_o(prescale_minus_one),
    .period_minus_one_o  (period_minus_one),
    .achieved_hz_o       (achieved_hz),
    .status_o            (status)
  );

  always #1 clk_i = ~clk_i;

  // Expected split of clk_hz / rate into prescaler and period
  function automatic timer_split_t split_timer_ratio(logic [DATA_W-1:0] clk_hz,
                                                     logic [DATA_W-1:0] rate);
    longint unsigned mask, ratio, mhz, root, cand, pm, p1, p2, prod;
    bit found, cut;
    timer_split_t res;
    res = '0;
    if (rate == 0 || clk_hz < rate) begin
      res.status = ST_BAD_RATE;
      return res;
    end
    mask = (64'd1 << COUNT_W) - 64'd1;
    ratio = 64'(clk_hz) / 64'(rate);
    mhz = 64'(clk_hz / TICK_HZ);
    // floor square root, built one bit at a time from the top
    root = 64'd0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= ratio) root = cand;
    end
    // downward search for an exact divisor that keeps the prescaled count in range
    found = 1'b0;
    p1 = 64'd0;
    p2 = 64'd0;
    for (pm = root; pm > 1 && !found; pm--) begin
      if (ratio % pm == 0 && pm * mhz <= mask) begin
        p1 = pm;
        p2 = ratio / pm;
        found = 1'b1;
      end
    end
    // no divisor: 1 MHz tick
    if (!found) begin
      p1 = mhz;
      p2 = 64'(TICK_HZ / rate);
    end
    cut = (p1 > mask) || (p2 > mask);
    p1 &= mask;
    p2 &= mask;
    prod = p1 * p2;
    res.prescale = COUNT_W'(p1 - 64'd1);
    res.period = COUNT_W'(p2 - 64'd1);
    res.achieved = (prod == 0) ? '0 : DATA_W'(64'(clk_hz) / prod);
    res.status = cut ? ST_TRUNC : ((prod == 0) ? ST_ZERO_DIV : ST_OK);
    return res;
  endfunction

  // Random request: mostly sensible ratios, some raw noise and edge values
  function automatic logic [DATA_W-1:0] pick_rate(logic [DATA_W-1:0] clk_hz);
    int unsigned sel, ratio;
    logic [DATA_W-1:0] r;
    sel = $urandom_range(99);
    if (sel < 20) begin
      r = $urandom();
    end else if (sel < 30) begin
      case ($urandom_range(4))
        0:       r = '0;
        1:       r = clk_hz;
        2:       r = clk_hz + 1;
        3:       r = clk_hz / 2;
        default: r = TICK_HZ;
      endcase
    end else begin
      ratio = ($urandom_range(9) == 0) ? $urandom_range(1, 200000) : $urandom_range(1, 4000);
      r = clk_hz / ratio + $urandom_range(0, 2);
      if (r == 0) r = 1;
    end
    return r;
  endfunction

  // Idle time before the next request: mostly none or short, sometimes long
  function automatic int next_gap();
    int unsigned sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(99);
    if (sel < 5) begin
      burst_left = $urandom_range(4, 12);
      return 0;
    end
    if (sel < 15) return $urandom_range(20, 150);
    if (sel < 50) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
  endtask

  task automatic add_random(input int n);
    for (int k = 0; k < n; k++) pending_rates.push_back(pick_rate(clock_model));
  endtask

  // Block idle: nothing queued, nothing offered, nothing outstanding
  task automatic settle();
    while (pending_rates.size() != 0 || start || expected_splits.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_clock(input logic [DATA_W-1:0] hz);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    clock_model = hz;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    clock_settings++;
  endtask

  // Request driver: holds a request until transferred, then gap or next one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !rate_taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_rates.size() != 0) begin
      start <= 1'b1;
      rate_hz <= pending_rates.pop_front();
      gap_left <= next_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on each request transfer, check each result strobe
  always @(posedge clk_i) begin : monitor
    timer_split_t want;
    if (rst_ni) begin
      rate_taken = start && !busy;
      if (rate_taken) begin
        expected_splits.push_back(split_timer_ratio(clock_model, rate_hz));
        requests_sent++;
      end
      if (done) begin
        if (expected_splits.size() == 0) begin
          report_mismatch("result with no request outstanding, status",
                          DATA_W'(status), '0);
        end else begin
          want = expected_splits.pop_front();
          status_seen[want.status]++;
          if (prescale_minus_one !== want.prescale)
            report_mismatch("prescale_minus_one", DATA_W'(prescale_minus_one),
                            DATA_W'(want.prescale));
          if (period_minus_one !== want.period)
            report_mismatch("period_minus_one", DATA_W'(period_minus_one),
                            DATA_W'(want.period));
          if (achieved_hz !== want.achieved)
            report_mismatch("achieved_hz", achieved_hz, want.achieved);
          if (status !== want.status)
            report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
        end
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset clock 72 MHz: bad requests, 1 MHz fallback with zero period, truncation
    pending_rates.push_back(32'd0);
    pending_rates.push_back(32'd72000001);
    pending_rates.push_back(32'hFFFF_FFFF);
    pending_rates.push_back(32'd72000000);
    pending_rates.push_back(32'd36000000);
    pending_rates.push_back(32'd1945945);
    pending_rates.push_back(32'd1000000);
    pending_rates.push_back(32'd999999);
    pending_rates.push_back(32'd1000);
    pending_rates.push_back(32'd50);
    pending_rates.push_back(32'd16);
    pending_rates.push_back(32'd15);
    pending_rates.push_back(32'd1);
    add_random(PHASE_RANDOM);
    settle();

    // lowest clock: 1 MHz, prescaler of one
    set_clock(32'd1000000);
    pending_rates.push_back(32'd1000000);
    pending_rates.push_back(32'd1000001);
    pending_rates.push_back(32'd7);
    pending_rates.push_back(32'd2);
    pending_rates.push_back(32'd1);
    add_random(PHASE_RANDOM);
    settle();

    // highest clock: divisor range tiny, long period truncated
    set_clock(32'hFFFF_FFFF);
    pending_rates.push_back(32'hFFFF_FFFF);
    pending_rates.push_back(32'h8000_0000);
    pending_rates.push_back(32'd65537);
    pending_rates.push_back(32'd1);
    add_random(PHASE_RANDOM);
    settle();

    // prime clock: no divisor at all, fallback period truncated
    set_clock(32'd4294967291);
    pending_rates.push_back(32'd1);
    pending_rates.push_back(32'd3);
    add_random(PHASE_RANDOM);
    settle();

    // random clock settings
    for (int k = 0; k < 3; k++) begin
      set_clock((k == 2) ? $urandom_range(1000000, 32'hFFFF_FFFF)
                         : $urandom_range(1000000, 200000000));
      add_random(PHASE_RANDOM);
      settle();
    end

    $display("Ran %0d requests over %0d clock settings: %0d ok, %0d bad rate,",
             requests_sent, clock_settings, status_seen[ST_OK], status_seen[ST_BAD_RATE]);
    $display("%0d zero divisor, %0d truncated; %0d mismatches",
             status_seen[ST_ZERO_DIV], status_seen[ST_TRUNC], mismatches);
    if (mismatches == 0) begin
      $display("timer_divider_factoring verification clean");
    end else begin
      $display("timer_divider_factoring verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin : watchdog
    #500_000_000;
    $display("Timeout with %0d results outstanding", expected_splits.size());
    $display("timer_divider_factoring verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tdf_pkg.sv
sv/tdf_divider.sv
sv/tdf_isqrt.sv
sv/timer_divider_factoring.sv
bench/timer_divider_factoring_test.sv
